>>> rtl/mfb_pkg.sv
// Shared types, sizes and action codes for the monochrome framebuffer engine.
package mfb_pkg;

  // Store geometry.
  localparam int WIDTH     = 32;
  localparam int HEIGHT    = 8;
  localparam int BANK_COLS = 16;

  // A single flush emits at most this many column bytes.
  localparam int MAX_FLUSH = 16;
  localparam int FLUSH_CNT = (BANK_COLS > MAX_FLUSH) ? MAX_FLUSH : BANK_COLS;

  // Index widths into the store.
  localparam int COL_W = $clog2(WIDTH);
  localparam int ROW_W = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;

  // Longest glyph row in pixels.
  localparam logic [3:0] GLYPH_MAX = 4'd8;

  // Action codes.
  localparam logic [2:0] ACT_SET   = 3'd0;
  localparam logic [2:0] ACT_GET   = 3'd1;
  localparam logic [2:0] ACT_CLEAR = 3'd2;
  localparam logic [2:0] ACT_GLYPH = 3'd3;
  localparam logic [2:0] ACT_FLUSH = 3'd4;

  // One input item.
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic       pixel_value;
    logic [7:0] glyph_bits;
    logic [3:0] glyph_width;
    logic       bank_select;
  } mfb_in_t;

  // One result item.
  typedef struct packed {
    logic       read_pixel;
    logic [7:0] column_byte;
    logic [7:0] next_x;
    logic       last_item;
  } mfb_out_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_GLYPH = 4'b0010,
    ST_CLEAR = 4'b0100,
    ST_FLUSH = 4'b1000
  } mfb_state_t;

endpackage

>>> rtl/mono_framebuffer_engine_unit.sv
// Monochrome framebuffer: pixel store, pixel and row write unit and action sequencer.
// Set pixel writes on acceptance; get pixel returns its item in the cycle after
// acceptance. Draw glyph row returns next_x likewise, then writes one pixel per cycle
// (up to 8). Clear sweeps one row per cycle; flush emits one column per unstalled cycle.
// All timing is set by the one shared pixel write port and the single output register.
// Synchronous active-low reset clears the store and the sequencer at once.
module mono_framebuffer_engine_unit
  import mfb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  mfb_in_t  in_item,
  output logic     out_valid,
  input  logic     out_stall,
  output mfb_out_t out_item
);

  localparam logic [ROW_W-1:0] CLR_LAST   = ROW_W'(HEIGHT - 1);
  localparam logic [3:0]       FLUSH_LAST = 4'(FLUSH_CNT - 1);

  // Pixel store: bit x of row y is column x.
  logic [WIDTH-1:0] pixel_rows_r [HEIGHT];

  mfb_state_t       state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  mfb_out_t         out_data_r, out_data_nxt;

  // Glyph walk registers.
  logic [COL_W-1:0] gcol_r, gcol_nxt;
  logic [ROW_W-1:0] grow_r, grow_nxt;
  logic [7:0]       gbits_r, gbits_nxt;
  logic [3:0]       gleft_r, gleft_nxt;

  // Clear sweep and flush counters.
  logic [ROW_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [7:0]       fcol_r, fcol_nxt;
  logic [3:0]       fidx_r, fidx_nxt;

  // Shared write unit controls.
  logic             wr_en, wr_clr, wr_val;
  logic [ROW_W-1:0] wr_row;
  logic [COL_W-1:0] wr_col;

  logic             out_free, accept, in_range, get_bit, col_ok, flush_last;
  logic [7:0]       room, glyph_n8, col_byte;
  logic [3:0]       w_sat, glyph_n;

  // Output register can take a new item when empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_data_r;

  // Coordinate check and single-pixel read for the current item.
  assign in_range = (in_item.x_pos < 8'(WIDTH)) && (in_item.y_pos < 8'(HEIGHT));
  assign get_bit  = in_range &&
                    pixel_rows_r[in_item.y_pos[ROW_W-1:0]][in_item.x_pos[COL_W-1:0]];

  // Glyph length clipped to eight pixels and to the room left in the row.
  assign w_sat    = (in_item.glyph_width > GLYPH_MAX) ? GLYPH_MAX : in_item.glyph_width;
  assign room     = 8'(WIDTH) - in_item.x_pos;
  assign glyph_n8 = ({4'd0, w_sat} < room) ? {4'd0, w_sat} : room;
  assign glyph_n  = glyph_n8[3:0];

  // Flush column gather: one column of all rows at once.
  assign col_ok     = fcol_r < 8'(WIDTH);
  assign flush_last = (fidx_r == FLUSH_LAST);
  always_comb begin
    col_byte = '0;
    for (int r = 0; r < HEIGHT; r++) begin
      col_byte[r] = col_ok && pixel_rows_r[r][fcol_r[COL_W-1:0]];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    gcol_nxt      = gcol_r;
    grow_nxt      = grow_r;
    gbits_nxt     = gbits_r;
    gleft_nxt     = gleft_r;
    clr_idx_nxt   = clr_idx_r;
    fcol_nxt      = fcol_r;
    fidx_nxt      = fidx_r;
    wr_en         = 1'b0;
    wr_clr        = 1'b0;
    wr_val        = 1'b0;
    wr_row        = in_item.y_pos[ROW_W-1:0];
    wr_col        = in_item.x_pos[COL_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_item.action)
            ACT_SET: begin
              wr_en  = in_range;
              wr_val = in_item.pixel_value;
            end
            ACT_GET: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{read_pixel: get_bit, column_byte: 8'd0,
                                next_x: 8'd0, last_item: 1'b1};
            end
            ACT_CLEAR: begin
              clr_idx_nxt = '0;
              state_nxt   = ST_CLEAR;
            end
            ACT_GLYPH: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{read_pixel: 1'b0, column_byte: 8'd0,
                                next_x: in_range ? (in_item.x_pos + {4'd0, w_sat} + 8'd1)
                                                 : in_item.x_pos,
                                last_item: 1'b1};
              gcol_nxt  = in_item.x_pos[COL_W-1:0];
              grow_nxt  = in_item.y_pos[ROW_W-1:0];
              gbits_nxt = in_item.glyph_bits;
              gleft_nxt = glyph_n;
              if (in_range && glyph_n != 4'd0) begin
                state_nxt = ST_GLYPH;
              end
            end
            ACT_FLUSH: begin
              fcol_nxt  = in_item.bank_select ? 8'(BANK_COLS) : 8'd0;
              fidx_nxt  = '0;
              state_nxt = ST_FLUSH;
            end
            default: begin
            end
          endcase
        end
      end
      ST_GLYPH: begin
        // One glyph pixel per cycle through the shared write port.
        wr_en     = 1'b1;
        wr_row    = grow_r;
        wr_col    = gcol_r;
        wr_val    = gbits_r[7];
        gcol_nxt  = gcol_r + COL_W'(1);
        gbits_nxt = {gbits_r[6:0], 1'b0};
        gleft_nxt = gleft_r - 4'd1;
        if (gleft_r == 4'd1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        // One row cleared per cycle.
        wr_clr      = 1'b1;
        wr_row      = clr_idx_r;
        clr_idx_nxt = clr_idx_r + ROW_W'(1);
        if (clr_idx_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        // One column byte per cycle while the output register has room.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{read_pixel: 1'b0, column_byte: col_byte,
                            next_x: 8'd0, last_item: flush_last};
          fcol_nxt      = fcol_r + 8'd1;
          fidx_nxt      = fidx_r + 4'd1;
          if (flush_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and counter registers.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    gcol_r     <= gcol_nxt;
    grow_r     <= grow_nxt;
    gbits_r    <= gbits_nxt;
    gleft_r    <= gleft_nxt;
    clr_idx_r  <= clr_idx_nxt;
    fcol_r     <= fcol_nxt;
    fidx_r     <= fidx_nxt;
  end

  // Shared write unit on the pixel store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < HEIGHT; r++) begin
        pixel_rows_r[r] <= '0;
      end
    end else if (wr_clr) begin
      pixel_rows_r[wr_row] <= '0;
    end else if (wr_en) begin
      pixel_rows_r[wr_row][wr_col] <= wr_val;
    end
  end

`ifndef SYNTHESIS
  // An accepted clear always starts the row sweep.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_item.action == ACT_CLEAR) |=> (state_r == ST_CLEAR))
    else $error("clear did not start the sweep");

  // The last row of the sweep is zeroed and the sequencer returns to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) && (clr_idx_r == CLR_LAST) |=>
      (pixel_rows_r[CLR_LAST] == '0) && (state_r == ST_IDLE))
    else $error("clear sweep left pixels set");

  // The final flush column carries last_item and returns the sequencer to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) && out_free && flush_last |=>
      (state_r == ST_IDLE) && out_valid_r && out_data_r.last_item)
    else $error("flush did not end on its last column");

  // A glyph walk always has between one and eight pixels left.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GLYPH) |-> (gleft_r != 4'd0) && (gleft_r <= GLYPH_MAX))
    else $error("glyph pixel count out of bounds");
`endif

endmodule
